FILE: design/scfg_pkg.sv
// Shared types and constants for the session cookie frame gate.
// Used by scfg_csr, scfg_step and the top level; depends on nothing.
package scfg_pkg;

   // Frame layout.
   localparam int HDR_BYTES        = 6;
   localparam int MIN_FRAME        = HDR_BYTES + 8;
   localparam int MAX_COOKIE_BYTES = 32;
   localparam int MAX_FRAME        = MIN_FRAME + MAX_COOKIE_BYTES;
   localparam logic [31:0] DEFAULT_TIMEOUT = 32'd10000;

   // Configuration register indexes.
   localparam logic [2:0] CSR_COOKIE0  = 3'd0;
   localparam logic [2:0] CSR_COOKIE1  = 3'd1;
   localparam logic [2:0] CSR_COOKIE2  = 3'd2;
   localparam logic [2:0] CSR_COOKIE3  = 3'd3;
   localparam logic [2:0] CSR_SECLEN   = 3'd4;
   localparam logic [2:0] CSR_CODE     = 3'd5;
   localparam logic [2:0] CSR_METHOD   = 3'd6;
   localparam logic [2:0] CSR_TIMEOUT  = 3'd7;

   typedef enum logic [1:0] {
      REQ_START = 2'd0,
      REQ_BYTE  = 2'd1,
      REQ_CLOSE = 2'd2,
      REQ_TICK  = 2'd3
   } req_kind_type;

   typedef enum logic [3:0] {
      VERDICT_NONE        = 4'd0,
      VERDICT_ACCEPTED    = 4'd1,
      VERDICT_NOT_COOKIE  = 4'd2,
      VERDICT_MALFORMED   = 4'd3,
      VERDICT_WRONG       = 4'd4,
      VERDICT_CLOSED      = 4'd5,
      VERDICT_TIMEOUT     = 4'd6,
      VERDICT_REPLACED    = 4'd7,
      VERDICT_REFUSED     = 4'd8
   } verdict_type;

   typedef struct packed {
      logic [255:0] secret;
      logic [5:0]   secret_length;
      logic [15:0]  expected_code;
      logic [31:0]  expected_method;
      logic [31:0]  timeout_ticks;
   } gate_cfg_type;

   typedef struct packed {
      logic        active;
      logic [5:0]  count;
      logic [47:0] header;
      logic [31:0] method;
      logic [31:0] cookie_len;
      logic        mismatch;
      logic [31:0] deadline;
   } gate_state_type;

   typedef struct packed {
      verdict_type verdict;
      logic        active;
      logic        speaking;
      logic [5:0]  bytes_taken;
   } gate_result_type;

endpackage

FILE: design/scfg_csr.sv
// Configuration registers of the session cookie frame gate.
// Depends on scfg_pkg for the register indexes and the configuration struct.
module scfg_csr import scfg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write_enable,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_wdata,
   output gate_cfg_type cfg
);

   gate_cfg_type cfg_ff;
   gate_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_COOKIE0: cfg_in.secret[63:0]    = csr_wdata;
            CSR_COOKIE1: cfg_in.secret[127:64]  = csr_wdata;
            CSR_COOKIE2: cfg_in.secret[191:128] = csr_wdata;
            CSR_COOKIE3: cfg_in.secret[255:192] = csr_wdata;
            CSR_SECLEN:  cfg_in.secret_length   = csr_wdata[5:0];
            CSR_CODE:    cfg_in.expected_code   = csr_wdata[15:0];
            CSR_METHOD:  cfg_in.expected_method = csr_wdata[31:0];
            CSR_TIMEOUT: cfg_in.timeout_ticks   = csr_wdata[31:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.secret          <= '0;
         cfg_ff.secret_length   <= '0;
         cfg_ff.expected_code   <= '0;
         cfg_ff.expected_method <= '0;
         cfg_ff.timeout_ticks   <= DEFAULT_TIMEOUT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/scfg_step.sv
// Combinational step of the gate: next candidate state and result for one transfer.
// Depends on scfg_pkg for the state, configuration and result types.
module scfg_step import scfg_pkg::*; (
   input  gate_cfg_type    cfg,
   input  gate_state_type  cur,
   input  logic [1:0]      req_type,
   input  logic [7:0]      data_byte,
   output gate_state_type  nxt,
   output gate_result_type res
);

   gate_state_type wiped;
   verdict_type    verdict;
   logic [5:0]     pos;
   logic [5:0]     cnt_n;
   logic [5:0]     eff_len;
   logic [5:0]     idx;
   logic [7:0]     sec_byte;
   logic [31:0]    hdr_len;
   logic [31:0]    frame_len;
   logic           diff;

   // The effective secret length is zero when the register is zero or out of range.
   assign eff_len = (cfg.secret_length > 6'(MAX_COOKIE_BYTES)) ? 6'd0 : cfg.secret_length;
   assign pos     = cur.count;
   assign cnt_n   = cur.count + 6'd1;
   assign idx     = pos - 6'(MIN_FRAME);
   assign sec_byte = cfg.secret[{idx[4:0], 3'b000} +: 8];
   assign frame_len = cur.header[47:16];

   always_comb begin
      wiped     = '0;
      nxt       = cur;
      verdict   = VERDICT_NONE;
      hdr_len   = '0;
      diff      = 1'b0;
      case (req_kind_type'(req_type))
         REQ_START: begin
            if (!cur.active || cur.count == 6'd0) begin
               nxt          = wiped;
               nxt.active   = 1'b1;
               nxt.deadline = cfg.timeout_ticks;
               verdict      = cur.active ? VERDICT_REPLACED : VERDICT_NONE;
            end else begin
               verdict = VERDICT_REFUSED;
            end
         end
         REQ_BYTE: begin
            if (cur.active) begin
               nxt.count = cnt_n;
               if (pos < 6'(HDR_BYTES)) begin
                  for (int k = 0; k < HDR_BYTES; k++) begin
                     if (pos == 6'(k)) begin
                        nxt.header[8*k +: 8] = data_byte;
                     end
                  end
                  hdr_len = nxt.header[47:16];
                  if (cnt_n == 6'(HDR_BYTES) &&
                      (nxt.header[15:0] != cfg.expected_code ||
                       hdr_len < 32'(MIN_FRAME) || hdr_len > 32'(MAX_FRAME))) begin
                     verdict = VERDICT_NOT_COOKIE;
                  end
               end else begin
                  if (pos < 6'(HDR_BYTES + 4)) begin
                     for (int k = 0; k < 4; k++) begin
                        if (pos == 6'(HDR_BYTES + k)) begin
                           nxt.method[8*k +: 8] = data_byte;
                        end
                     end
                  end else if (pos < 6'(MIN_FRAME)) begin
                     for (int k = 0; k < 4; k++) begin
                        if (pos == 6'(HDR_BYTES + 4 + k)) begin
                           nxt.cookie_len[8*k +: 8] = data_byte;
                        end
                     end
                  end else if (idx < eff_len && data_byte != sec_byte) begin
                     nxt.mismatch = 1'b1;
                  end
                  // The whole frame is in: check method, length, then the cookie.
                  if ({26'd0, cnt_n} >= frame_len) begin
                     if (nxt.method != cfg.expected_method ||
                         ({1'b0, nxt.cookie_len} + 33'(MIN_FRAME)) != {1'b0, frame_len}) begin
                        verdict = VERDICT_MALFORMED;
                     end else begin
                        diff = nxt.mismatch || (nxt.cookie_len != {26'd0, eff_len}) ||
                               (eff_len == 6'd0);
                        verdict = diff ? VERDICT_WRONG : VERDICT_ACCEPTED;
                     end
                  end
               end
               if (verdict != VERDICT_NONE) begin
                  nxt = wiped;
               end
            end
         end
         REQ_CLOSE: begin
            if (cur.active) begin
               nxt     = wiped;
               verdict = VERDICT_CLOSED;
            end
         end
         default: begin
            if (cur.active) begin
               if (cur.deadline == 32'd0) begin
                  nxt     = wiped;
                  verdict = VERDICT_TIMEOUT;
               end else begin
                  nxt.deadline = cur.deadline - 32'd1;
               end
            end
         end
      endcase
   end

   always_comb begin
      res.verdict     = verdict;
      res.active      = nxt.active;
      res.speaking    = nxt.active && (nxt.count != 6'd0);
      res.bytes_taken = nxt.active ? nxt.count : 6'd0;
   end

endmodule

FILE: design/session_cookie_frame_gate_unit.sv
// Top level of the session cookie frame gate: handshake pipeline and candidate state.
// Depends on scfg_pkg, scfg_csr and scfg_step.

// Every transfer on the request channel (start, data byte, peer close or
// tick) produces exactly one result transfer. The block takes one request per
// clock cycle: a request lands in an input register, then the candidate step
// is evaluated against the stored candidate state and the result is written
// into the output register, so throughput is one transfer per cycle while
// rsp_ready stays high. The single candidate state register, updated once per
// step, sets that rate. A stalled result holds the pipeline only when both
// registers are full. Configuration writes take effect at the next edge and
// must be made while the block is idle. There is no clearing pass after
// reset; the block is ready right away.
module session_cookie_frame_gate_unit import scfg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_data_byte,
   // Result channel.
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_verdict,
   output logic        rsp_candidate_active,
   output logic        rsp_candidate_speaking,
   output logic [5:0]  rsp_bytes_taken,
   // Configuration write port.
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   gate_cfg_type    cfg;
   gate_state_type  state_ff;
   gate_state_type  state_in;
   gate_result_type step_res;
   gate_result_type res_ff;

   logic       in_vld_ff;
   logic       in_vld_in;
   logic [1:0] in_type_ff;
   logic [7:0] in_byte_ff;
   logic       out_vld_ff;
   logic       out_vld_in;
   logic       advance;
   logic       req_take;

   scfg_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg)
   );

   scfg_step u_step (
      .cfg       (cfg),
      .cur       (state_ff),
      .req_type  (in_type_ff),
      .data_byte (in_byte_ff),
      .nxt       (state_in),
      .res       (step_res)
   );

   // A stored request moves on when the result register is empty or being drained.
   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      if (advance) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         state_ff   <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_type_ff <= req_type;
         in_byte_ff <= req_data_byte;
      end
      if (advance) begin
         res_ff <= step_res;
      end
   end

   assign rsp_valid              = out_vld_ff;
   assign rsp_verdict            = res_ff.verdict;
   assign rsp_candidate_active   = res_ff.active;
   assign rsp_candidate_speaking = res_ff.speaking;
   assign rsp_bytes_taken        = res_ff.bytes_taken;

   // An idle gate holds no partial frame.
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !state_ff.active |-> (state_ff.count == 6'd0))
      else $error("idle gate holds a byte count");

   // A candidate never takes more bytes than the longest frame.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.count <= 6'(MAX_FRAME))
      else $error("byte count beyond the longest frame");

   // A speaking result always belongs to an active candidate.
   a_speaking: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_candidate_speaking |-> rsp_candidate_active)
      else $error("speaking without an active candidate");

   // An accepted request is held in the input register on the next cycle.
   a_capture: assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_vld_ff)
      else $error("accepted request was lost");

endmodule

FILE: dv/session_cookie_frame_gate_unit_tb.sv
// Self-checking testbench for the session cookie frame gate top level.
// Depends on scfg_pkg and session_cookie_frame_gate_unit; drives valid/ready traffic,
// programs the configuration registers between phases and scores every result transfer.
module session_cookie_frame_gate_unit_tb import scfg_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   // The run is cut off here.
   localparam int CYCLE_LIMIT = 500000;
   // Number of accepted requests after which the receiver holds off once.
   localparam int HOLD_AT     = 200;
   localparam int HOLD_CYCLES = 240;

   typedef struct {
      req_kind_type kind;
      logic [7:0]   data;
   } gate_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type = REQ_TICK;
   logic [7:0]  req_data_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_verdict;
   logic        rsp_candidate_active;
   logic        rsp_candidate_speaking;
   logic [5:0]  rsp_bytes_taken;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = CSR_COOKIE0;
   logic [63:0] csr_wdata = 64'd0;

   session_cookie_frame_gate_unit u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_type               (req_type),
      .req_data_byte          (req_data_byte),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_verdict            (rsp_verdict),
      .rsp_candidate_active   (rsp_candidate_active),
      .rsp_candidate_speaking (rsp_candidate_speaking),
      .rsp_bytes_taken        (rsp_bytes_taken),
      .csr_write_enable       (csr_write_enable),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Requests waiting to be offered, and one expected result per accepted request.
   gate_req_type    outbound[$];
   gate_result_type verdicts_due[$];

   int  queued_total = 0;
   int  items_taken = 0;
   int  mismatches = 0;
   int  cycle_count = 0;
   // Chance in percent that a side starts an idle burst; set per phase, zero at the end.
   int  idle_pct = 0;
   // Chance in percent that a tick is slipped in ahead of a frame byte.
   int  tick_pct = 0;
   logic rx_holding = 1'b0;

   // Shadow copy of the configuration registers, as the block should see them.
   logic [255:0] k_secret  = '0;
   logic [5:0]   k_seclen  = '0;
   logic [15:0]  k_code    = '0;
   logic [31:0]  k_method  = '0;
   logic [31:0]  k_timeout = DEFAULT_TIMEOUT;

   // Shadow copy of the candidate being checked.
   logic         g_active   = 1'b0;
   logic [5:0]   g_count    = '0;
   logic [47:0]  g_header   = '0;
   logic [31:0]  g_method   = '0;
   logic [31:0]  g_cookie_len = '0;
   logic         g_mismatch = 1'b0;
   logic [31:0]  g_deadline = '0;

   // ------------------------------------------------------------------
   // Candidate prediction
   // ------------------------------------------------------------------

   // Every way a candidate ends leaves the gate exactly as it was after reset.
   function automatic void drop_candidate();
      g_active     = 1'b0;
      g_count      = '0;
      g_header     = '0;
      g_method     = '0;
      g_cookie_len = '0;
      g_mismatch   = 1'b0;
      g_deadline   = '0;
   endfunction

   function automatic void open_candidate();
      drop_candidate();
      g_active   = 1'b1;
      g_deadline = k_timeout;
   endfunction

   // Folds one frame byte into the candidate and returns the verdict it causes.
   function automatic verdict_type take_frame_byte(logic [7:0] b);
      int          pos;
      int          seclen;
      logic [31:0] flen;
      logic        diff;
      pos     = g_count;
      g_count = g_count + 6'd1;
      // A secret length of zero or beyond the cookie store means no secret at all.
      seclen  = (k_seclen == 0 || k_seclen > MAX_COOKIE_BYTES) ? 0 : int'(k_seclen);
      if (pos < HDR_BYTES) begin
         g_header[8*pos +: 8] = b;
         // The header is judged as soon as its last byte is in.
         if (g_count == HDR_BYTES) begin
            if (g_header[15:0] != k_code || g_header[47:16] < MIN_FRAME
                || g_header[47:16] > MAX_FRAME)
               return VERDICT_NOT_COOKIE;
         end
         return VERDICT_NONE;
      end
      if (pos < HDR_BYTES + 4)
         g_method[8*(pos-HDR_BYTES) +: 8] = b;
      else if (pos < MIN_FRAME)
         g_cookie_len[8*(pos-HDR_BYTES-4) +: 8] = b;
      else if (pos - MIN_FRAME < seclen && b != k_secret[8*(pos-MIN_FRAME) +: 8])
         // Cookie bytes past the secret are never compared; the length check fails them.
         g_mismatch = 1'b1;
      flen = g_header[47:16];
      if (g_count < flen)
         return VERDICT_NONE;
      // The length field is compared without wrapping at 32 bits.
      if (g_method != k_method || {1'b0, g_cookie_len} + 33'(MIN_FRAME) != {1'b0, flen})
         return VERDICT_MALFORMED;
      diff = g_mismatch || g_cookie_len != seclen || seclen == 0;
      return diff ? VERDICT_WRONG : VERDICT_ACCEPTED;
   endfunction

   // Advances the shadow candidate by one accepted request and files the expected result.
   task automatic judge_request(req_kind_type kind, logic [7:0] b);
      verdict_type     v;
      gate_result_type r;
      v = VERDICT_NONE;
      case (kind)
         REQ_START: begin
            if (!g_active)
               open_candidate();
            else if (g_count == 0) begin
               // A silent candidate gives way to the new one.
               open_candidate();
               v = VERDICT_REPLACED;
            end else
               v = VERDICT_REFUSED;
         end
         REQ_BYTE: begin
            if (g_active) begin
               v = take_frame_byte(b);
               if (v != VERDICT_NONE)
                  drop_candidate();
            end
         end
         REQ_CLOSE: begin
            if (g_active) begin
               drop_candidate();
               v = VERDICT_CLOSED;
            end
         end
         default: begin
            // The deadline runs out on the tick after the counter has reached zero.
            if (g_active) begin
               if (g_deadline == 0) begin
                  drop_candidate();
                  v = VERDICT_TIMEOUT;
               end else
                  g_deadline = g_deadline - 32'd1;
            end
         end
      endcase
      r.verdict     = v;
      r.active      = g_active;
      r.speaking    = g_active && g_count != 0;
      r.bytes_taken = g_active ? g_count : 6'd0;
      verdicts_due.push_back(r);
   endtask

   // ------------------------------------------------------------------
   // Request side: the driver offers queued requests and scores each transfer
   // into the predictor at the edge where it happens.
   // ------------------------------------------------------------------
   int           send_gap = 0;
   gate_req_type next_req;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            judge_request(req_kind_type'(req_type), req_data_byte);
            items_taken <= items_taken + 1;
         end
         // Valid and payload change only once the offered item has gone.
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (outbound.size() != 0) begin
               next_req = outbound.pop_front();
               req_valid     <= 1'b1;
               req_type      <= next_req.kind;
               req_data_byte <= next_req.data;
               // No gaps while the receiver holds off, so the block has to fill up.
               if (!rx_holding && $urandom_range(0, 99) < idle_pct)
                  send_gap = $urandom_range(1, 16);
            end else
               req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Result side: ready with random stall bursts, plus one long hold-off once
   // enough requests have gone in.
   // ------------------------------------------------------------------
   int   ready_gap = 0;
   int   hold_left = 0;
   logic hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         rx_holding <= 1'b0;
      end else begin
         if (!hold_done && items_taken >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready  <= 1'b0;
            rx_holding <= 1'b1;
         end else if (ready_gap > 0) begin
            ready_gap--;
            rsp_ready  <= 1'b0;
            rx_holding <= 1'b0;
         end else begin
            rsp_ready  <= 1'b1;
            rx_holding <= 1'b0;
            if ($urandom_range(0, 99) < idle_pct)
               ready_gap = $urandom_range(1, 16);
         end
      end
   end

   task automatic flag_mismatch(string what, int got, int want);
      $display("ERROR at %0t ns: %s got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // Each result transfer is held against the oldest outstanding expectation.
   gate_result_type want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdicts_due.size() == 0)
            flag_mismatch("result with nothing outstanding, verdict", rsp_verdict, 0);
         else begin
            want = verdicts_due.pop_front();
            if (rsp_verdict !== want.verdict)
               flag_mismatch("verdict", rsp_verdict, want.verdict);
            if (rsp_candidate_active !== want.active)
               flag_mismatch("candidate_active", rsp_candidate_active, want.active);
            if (rsp_candidate_speaking !== want.speaking)
               flag_mismatch("candidate_speaking", rsp_candidate_speaking, want.speaking);
            if (rsp_bytes_taken !== want.bytes_taken)
               flag_mismatch("bytes_taken", rsp_bytes_taken, want.bytes_taken);
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and configuration
   // ------------------------------------------------------------------

   task automatic push_req(req_kind_type kind, logic [7:0] data);
      gate_req_type item;
      item.kind = kind;
      item.data = data;
      outbound.push_back(item);
      queued_total++;
   endtask

   // Writes one register; the shadow copy follows at once since the block is idle.
   task automatic csr_put(logic [2:0] idx, logic [63:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= value;
      case (idx)
         CSR_COOKIE0: k_secret[63:0]    = value;
         CSR_COOKIE1: k_secret[127:64]  = value;
         CSR_COOKIE2: k_secret[191:128] = value;
         CSR_COOKIE3: k_secret[255:192] = value;
         CSR_SECLEN:  k_seclen          = value[5:0];
         CSR_CODE:    k_code            = value[15:0];
         CSR_METHOD:  k_method          = value[31:0];
         default:     k_timeout         = value[31:0];
      endcase
   endtask

   task automatic program_gate(logic [255:0] secret, logic [5:0] seclen, logic [15:0] code,
                               logic [31:0] method, logic [31:0] timeout);
      csr_put(CSR_COOKIE0, secret[63:0]);
      csr_put(CSR_COOKIE1, secret[127:64]);
      csr_put(CSR_COOKIE2, secret[191:128]);
      csr_put(CSR_COOKIE3, secret[255:192]);
      csr_put(CSR_SECLEN, {58'd0, seclen});
      csr_put(CSR_CODE, {48'd0, code});
      csr_put(CSR_METHOD, {32'd0, method});
      csr_put(CSR_TIMEOUT, {32'd0, timeout});
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [255:0] random_secret();
      return {$urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom};
   endfunction

   // Queues one candidate: a start and a frame built against the current settings.
   // Roughly half the frames are clean; the rest carry one flaw each.
   task automatic queue_frame();
      logic [7:0]  fb[$];
      logic [15:0] code;
      logic [31:0] flen;
      logic [31:0] meth;
      logic [31:0] clen;
      int          n;
      int          seclen;
      int          flaw;
      int          cut;
      int          i;
      seclen = (k_seclen == 0 || k_seclen > MAX_COOKIE_BYTES) ? 0 : int'(k_seclen);
      n      = (seclen != 0 && $urandom_range(0, 9) < 7) ? seclen
                                                       : $urandom_range(0, MAX_COOKIE_BYTES);
      code   = k_code;
      flen   = MIN_FRAME + n;
      meth   = k_method;
      clen   = n;
      flaw   = $urandom_range(0, 15);
      case (flaw)
         0: code = code ^ (16'd1 << $urandom_range(0, 15));
         1: begin
            case ($urandom_range(0, 3))
               0:       flen = 32'd0;
               1:       flen = MIN_FRAME - 1;
               2:       flen = MAX_FRAME + 1;
               default: flen = $urandom;
            endcase
         end
         2: meth = meth ^ (32'd1 << $urandom_range(0, 31));
         3: clen = $urandom_range(0, 1) ? 32'hFFFF_FFFF : clen ^ (32'd1 << $urandom_range(0, 31));
         // Header length disagrees with the bytes that follow, so frames run into each other.
         5: flen = MIN_FRAME + $urandom_range(0, MAX_COOKIE_BYTES);
         default: ;
      endcase
      for (i = 0; i < 2; i++) fb.push_back(code[8*i +: 8]);
      for (i = 0; i < 4; i++) fb.push_back(flen[8*i +: 8]);
      for (i = 0; i < 4; i++) fb.push_back(meth[8*i +: 8]);
      for (i = 0; i < 4; i++) fb.push_back(clen[8*i +: 8]);
      for (i = 0; i < n; i++) fb.push_back(i < seclen ? k_secret[8*i +: 8] : 8'($urandom));
      if (flaw == 4 && n > 0) begin
         i = $urandom_range(0, n - 1);
         fb[MIN_FRAME + i] ^= 8'(1 << $urandom_range(0, 7));
      end

      push_req(REQ_START, 8'($urandom));
      // A second start before any byte replaces the silent candidate.
      if (flaw == 8)
         push_req(REQ_START, 8'($urandom));
      // The peer may hang up partway through.
      cut = (flaw == 6) ? $urandom_range(0, fb.size() - 1) : fb.size();
      for (i = 0; i < cut; i++) begin
         if ($urandom_range(0, 99) < tick_pct)
            push_req(REQ_TICK, 8'($urandom));
         // A start from a talking candidate is refused.
         if (flaw == 7 && i == cut / 2)
            push_req(REQ_START, 8'($urandom));
         push_req(REQ_BYTE, fb[i]);
      end
      if (flaw == 6)
         push_req(REQ_CLOSE, 8'($urandom));
   endtask

   task automatic queue_phase(int count);
      int goal;
      goal = queued_total + count;
      while (queued_total < goal) begin
         if ($urandom_range(0, 9) < 8)
            queue_frame();
         else
            repeat ($urandom_range(1, 4))
               push_req(req_kind_type'($urandom_range(0, 3)), 8'($urandom));
      end
   endtask

   // Returns once nothing is queued, nothing is offered and every result is in.
   task automatic await_quiet();
      do
         @(negedge clock);
      while (outbound.size() != 0 || req_valid || verdicts_due.size() != 0);
   endtask

   // One configuration phase: wait for the block to go idle, program every
   // register, then feed a batch of random frames and let it drain.
   task automatic run_phase(logic [255:0] secret, logic [5:0] seclen, logic [15:0] code,
                            logic [31:0] method, logic [31:0] timeout, int ticks, int idle);
      await_quiet();
      repeat (4) @(posedge clock);
      program_gate(secret, seclen, code, method, timeout);
      @(negedge clock);
      tick_pct = ticks;
      idle_pct = idle;
      queue_phase(225);
      await_quiet();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: a deadline of one tick, and a code at its top value.
      program_gate(random_secret(), 6'd4, 16'hFFFF, 32'd0, 32'd1);
      @(negedge clock);
      idle_pct = 10;
      // Requests with no candidate are ignored.
      push_req(REQ_TICK, 8'h00);
      push_req(REQ_BYTE, 8'hFF);
      push_req(REQ_CLOSE, 8'h00);
      // Start, replace while silent, then run out the deadline.
      push_req(REQ_START, 8'hFF);
      push_req(REQ_START, 8'h00);
      push_req(REQ_TICK, 8'hFF);
      push_req(REQ_TICK, 8'h00);
      // Refused start once the candidate talks, then a peer close.
      push_req(REQ_START, 8'h00);
      push_req(REQ_BYTE, 8'hFF);
      push_req(REQ_START, 8'hFF);
      push_req(REQ_CLOSE, 8'hFF);
      // A header whose length is one past the largest frame.
      push_req(REQ_START, 8'h00);
      push_req(REQ_BYTE, 8'hFF);
      push_req(REQ_BYTE, 8'hFF);
      push_req(REQ_BYTE, 8'(MAX_FRAME + 1));
      push_req(REQ_BYTE, 8'h00);
      push_req(REQ_BYTE, 8'h00);
      push_req(REQ_BYTE, 8'h00);
      // A code byte of zero misses the expected code.
      push_req(REQ_START, 8'hFF);
      push_req(REQ_BYTE, 8'h00);
      push_req(REQ_BYTE, 8'hFF);
      push_req(REQ_BYTE, 8'd14);
      push_req(REQ_BYTE, 8'h00);
      push_req(REQ_BYTE, 8'h00);
      push_req(REQ_BYTE, 8'h00);

      // Random phases. The first one carries the long receiver hold-off.
      run_phase(random_secret(), 6'd32, 16'($urandom), $urandom, DEFAULT_TIMEOUT, 3, 10);
      // No secret: the gate must fail closed on every complete frame.
      run_phase('0, 6'd0, 16'd0, 32'd0, 32'hFFFF_FFFF, 3, 20);
      run_phase('1, 6'd1, 16'hFFFF, 32'hFFFF_FFFF, 32'd1, 4, 5);
      run_phase(random_secret(), 6'($urandom_range(1, 32)), 16'($urandom), $urandom,
                32'($urandom_range(2, 30)), 5, 10);
      run_phase(random_secret(), 6'($urandom_range(0, 32)), 16'($urandom), $urandom,
                32'($urandom_range(1, 400)), 3, 20);
      // Closing stretch at full rate on both sides.
      run_phase(random_secret(), 6'($urandom_range(1, 32)), 16'($urandom), $urandom,
                DEFAULT_TIMEOUT, 2, 0);

      await_quiet();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: filelist.f
design/scfg_pkg.sv
design/scfg_csr.sv
design/scfg_step.sv
design/session_cookie_frame_gate_unit.sv
dv/session_cookie_frame_gate_unit_tb.sv
